// ----- sv/sid_pkg.sv -----
// ----------------------------------------------------------------------------
// sid_pkg: shared types and constants of the signed integer divider
// Default width, result status codes, sequencer states and unit status.
// ----------------------------------------------------------------------------
`default_nettype none

package sid_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    // Status of the iterative unit as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

// ----- sv/sid_div_unit.sv -----
// ----------------------------------------------------------------------------
// sid_div_unit: iterative unsigned shift-subtract divider
// Retires one quotient bit per cycle through one shared subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_div_unit #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [DATA_WIDTH-1:0]   dividend,
    input  wire logic [DATA_WIDTH-1:0]   divisor,
    output sid_pkg::unit_stat_t          stat,
    output logic      [DATA_WIDTH-1:0]   quo
);

    localparam int CntW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] div_reg, div_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;

    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH+1:0] diff;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DATA_WIDTH-1]};
        diff      = {1'b0, rem_shift} - {2'b00, div_reg};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;

        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = CntW'(DATA_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the difference when no borrow, else restore
            if (!diff[DATA_WIDTH+1])
            begin
                rem_next = diff[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = !busy_reg;
    assign quo       = quo_reg;

endmodule

`default_nettype wire

// ----- sv/signed_integer_divider_core.sv -----
// ----------------------------------------------------------------------------
// signed_integer_divider_core: signed division truncated toward zero
// Strips signs, divides magnitudes one bit per cycle, then fixes the sign,
// flags divide by zero and saturates the one overflowing case.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_ready  | numerator, denominator (signed)
//  out     | out_valid / out_ready| quotient (signed), status (2 bits)
//
//  An item passes from accept to a loaded result in one accept step,
//  DATA_WIDTH iterations of the shared subtractor in sid_div_unit, and
//  one step to fix and register the result.
//  in_ready is high only while the sequencer is idle; a result waiting
//  on out_ready does not block the next accept, but a finished quotient
//  holds in the unit until the output register frees up.
//  Reset clears sequencer, unit control and output valid; payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_divider_core #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] numerator,
    input  wire logic signed [DATA_WIDTH-1:0] denominator,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0]      quotient,
    output logic [1:0]                        status
);

    sid_pkg::state_t     state_reg, state_next;
    sid_pkg::unit_stat_t unit_stat;

    // Operand flags captured at accept
    logic neg_a_reg, neg_a_next;
    logic neg_b_reg, neg_b_next;
    logic zero_reg,  zero_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] quotient_reg,  quotient_next;
    sid_pkg::status_t      status_reg,    status_next;

    logic                  accept;
    logic                  load;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [DATA_WIDTH-1:0] unit_quo;
    logic [DATA_WIDTH-1:0] quo_neg;

    localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // Magnitudes: the most negative value maps to 2^(W-1), still W bits unsigned
    assign mag_a = numerator[DATA_WIDTH-1]
                 ? (~$unsigned(numerator) + DATA_WIDTH'(1)) : $unsigned(numerator);
    assign mag_b = denominator[DATA_WIDTH-1]
                 ? (~$unsigned(denominator) + DATA_WIDTH'(1)) : $unsigned(denominator);

    sid_div_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (mag_a),
        .divisor  (mag_b),
        .stat     (unit_stat),
        .quo      (unit_quo)
    );

    assign quo_neg = ~unit_quo + DATA_WIDTH'(1);

    // Sequencer: accept in idle, wait for the unit, then load the output
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        accept         = 1'b0;
        load           = 1'b0;
        neg_a_next     = neg_a_reg;
        neg_b_next     = neg_b_reg;
        zero_next      = zero_reg;
        quotient_next  = quotient_reg;
        status_next    = status_reg;

        case (state_reg)
            sid_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    accept     = 1'b1;
                    neg_a_next = numerator[DATA_WIDTH-1];
                    neg_b_next = denominator[DATA_WIDTH-1];
                    zero_next  = (denominator == '0);
                    state_next = sid_pkg::ST_RUN;
                end
            end
            sid_pkg::ST_RUN:
            begin
                // hold the finished quotient until the output register is free
                if (unit_stat.done && (!out_valid_reg || out_ready))
                begin
                    load       = 1'b1;
                    state_next = sid_pkg::ST_IDLE;
                    if (zero_reg)
                    begin
                        quotient_next = '0;
                        status_next   = sid_pkg::STATUS_DIV_ZERO;
                    end
                    else if (neg_a_reg != neg_b_reg)
                    begin
                        quotient_next = quo_neg;
                        status_next   = sid_pkg::STATUS_OK;
                    end
                    else if (unit_quo[DATA_WIDTH-1])
                    begin
                        // most negative over minus one: saturate
                        quotient_next = MaxPos;
                        status_next   = sid_pkg::STATUS_OVERFLOW;
                    end
                    else
                    begin
                        quotient_next = unit_quo;
                        status_next   = sid_pkg::STATUS_OK;
                    end
                end
            end
            default:
            begin
                state_next = sid_pkg::ST_IDLE;
            end
        endcase
    end

    // Output beat: set on load, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sid_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_a_reg    <= neg_a_next;
        neg_b_reg    <= neg_b_next;
        zero_reg     <= zero_next;
        quotient_reg <= quotient_next;
        status_reg   <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign quotient  = $signed(quotient_reg);
    assign status    = status_reg;

`ifndef ASSERT_OFF
    // The unit never iterates while a new beat can be taken
    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && unit_stat.busy))
        else $error("input ready while divider unit busy");

    // An accepted beat starts the unit on the next cycle
    a_accept_starts_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> unit_stat.busy)
        else $error("divider unit did not start after accept");

    // Divide by zero always reports a zero quotient
    a_div_zero_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == sid_pkg::STATUS_DIV_ZERO) |-> (quotient == '0))
        else $error("divide by zero with nonzero quotient");

    // Saturation only produces the largest positive value
    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == sid_pkg::STATUS_OVERFLOW) |-> (quotient_reg == MaxPos))
        else $error("overflow status without saturated quotient");
`endif

endmodule

`default_nettype wire
